// ===== sv/arf_pkg.sv =====
`timescale 1ns / 1ps

package arf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = 2 * MAG_BITS;
   localparam int ENV_BITS = 16;
   localparam int SUM_BITS = 48;
   localparam int INDEX_BITS = 32;

   localparam logic [2:0] CSR_ATTACK = 3'd0;
   localparam logic [2:0] CSR_RELEASE = 3'd1;
   localparam logic [2:0] CSR_MODE = 3'd2;
   localparam logic [2:0] CSR_CHANNELS = 3'd3;
   localparam logic [2:0] CSR_INTERVAL = 3'd4;

   localparam logic DETECT_SQUARE = 1'b0;
   localparam logic DETECT_PEAK = 1'b1;
   localparam logic [1:0] CHANNELS_STEREO = 2'd2;

   localparam logic KIND_POINT = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
      logic last_frame;
   } req_type;

   typedef struct packed {
      logic result_kind;
      logic [ENV_BITS-1:0] envelope;
      logic [INDEX_BITS-1:0] frame_index;
      logic [SUM_BITS-1:0] amplitude_sum;
      logic [31:0] point_count;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] attack_coefficient;
      logic [15:0] release_coefficient;
      logic detector_mode;
      logic [1:0] channel_count;
      logic [15:0] points_interval;
   } cfg_type;

   typedef struct packed {
      logic [MAG_BITS-1:0] magnitude;
      logic last_frame;
   } item_type;

endpackage

// ===== sv/attack_release_envelope_follower.sv =====
`timescale 1ns / 1ps

// Attack/release envelope follower. Each item is one audio frame; its magnitude is formed as it
// enters a two-item queue, and a sequencer then squares it (or takes the peak), runs the one-pole
// smoother and updates the run counters, one multiplier step per cycle. A frame takes the detect,
// smoothing and point steps, then a summary step if it is last; each new frame is taken as the
// one before leaves these steps. Results go out through a two-item queue; an envelope point is
// emitted on every frame at the start of a point interval, and the last frame of a run adds a
// summary with the saturating sum and count of the run's points. Configuration is written through
// the csr port; the user must do so only while no frame is in flight; the block does not check.
module attack_release_envelope_follower #(
   parameter int COUNT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  arf_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output arf_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);

   import arf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   item_type item;
   logic item_valid;
   logic item_pop;
   logic out_full;
   logic out_push;
   rsp_type out_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ATTACK: cfg_in.attack_coefficient = csr_data;
            CSR_RELEASE: cfg_in.release_coefficient = csr_data;
            CSR_MODE: cfg_in.detector_mode = csr_data[0];
            CSR_CHANNELS: cfg_in.channel_count = csr_data[1:0];
            CSR_INTERVAL: cfg_in.points_interval = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_coefficient <= 16'd65387;
         cfg_ff.release_coefficient <= 16'd65521;
         cfg_ff.detector_mode <= DETECT_SQUARE;
         cfg_ff.channel_count <= 2'd1;
         cfg_ff.points_interval <= 16'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arf_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .push(push),
      .req_data(req_data),
      .full(full),
      .item_valid(item_valid),
      .item_pop(item_pop),
      .item(item)
   );

   arf_back #(
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .item_valid(item_valid),
      .item(item),
      .item_pop(item_pop),
      .out_full(out_full),
      .out_push(out_push),
      .out_data(out_data)
   );

   arf_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(2)
   ) u_result_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .push_data(out_data),
      .full(out_full),
      .pop(pop),
      .pop_data(rsp_data),
      .empty(empty)
   );

endmodule

// ===== sv/arf_fifo.sv =====
`timescale 1ns / 1ps

module arf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fifo count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("fifo count did not shrink on pop");

endmodule

// ===== sv/arf_front.sv =====
`timescale 1ns / 1ps

module arf_front (
   input  logic              clock,
   input  logic              reset,
   input  arf_pkg::cfg_type  cfg,
   input  logic              push,
   input  arf_pkg::req_type  req_data,
   output logic              full,
   output logic              item_valid,
   input  logic              item_pop,
   output arf_pkg::item_type item
);

   import arf_pkg::*;

   logic signed [MAG_BITS-1:0] frame_value;
   logic [MAG_BITS-1:0] magnitude;
   item_type classified;
   logic queue_empty;

   // The frame value is kept at twice the sample scale so that the stereo average is exact.
   always_comb begin
      if (cfg.channel_count == CHANNELS_STEREO) begin
         frame_value = MAG_BITS'(req_data.sample_left) + MAG_BITS'(req_data.sample_right);
      end else begin
         frame_value = {req_data.sample_left, 1'b0};
      end
      magnitude = frame_value[MAG_BITS-1] ? MAG_BITS'(-frame_value) : MAG_BITS'(frame_value);
      classified.magnitude = magnitude;
      classified.last_frame = req_data.last_frame;
   end

   arf_fifo #(
      .WIDTH($bits(item_type)),
      .DEPTH(2)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(classified),
      .full(full),
      .pop(item_pop),
      .pop_data(item),
      .empty(queue_empty)
   );

   assign item_valid = !queue_empty;

endmodule

// ===== sv/arf_back.sv =====
`timescale 1ns / 1ps

module arf_back #(
   parameter int COUNT_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  arf_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  arf_pkg::item_type item,
   output logic              item_pop,
   input  logic              out_full,
   output logic              out_push,
   output arf_pkg::rsp_type  out_data
);

   import arf_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DETECT = 3'd1;
   localparam logic [2:0] S_SMOOTH1 = 3'd2;
   localparam logic [2:0] S_SMOOTH2 = 3'd3;
   localparam logic [2:0] S_POINT = 3'd4;
   localparam logic [2:0] S_SUMMARY = 3'd5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
   localparam logic [ENV_BITS:0] UNITY = (ENV_BITS + 1)'(1) << ENV_BITS;

   logic [2:0] state_ff, state_in;
   logic [MAG_BITS-1:0] mag_ff, mag_in;
   logic last_ff, last_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [ENV_BITS-1:0] det_ff, det_in;
   logic [15:0] coef_ff, coef_in;
   logic [2*ENV_BITS-1:0] acc_ff, acc_in;
   logic [ENV_BITS-1:0] env_ff, env_in;
   logic [COUNT_BITS-1:0] frame_ff, frame_in;
   logic [15:0] phase_ff, phase_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   logic [ENV_BITS-1:0] det_value;
   logic [ENV_BITS:0] coef_rest;
   logic [2*ENV_BITS:0] rel_prod;
   logic [2*ENV_BITS:0] smooth_sum;
   logic [SUM_BITS:0] sum_add;
   logic [15:0] interval;
   logic [16:0] phase_next;
   logic point_due;
   logic point_go;
   logic summary_go;
   logic take;

   assign point_due = (phase_ff == '0);
   assign point_go = (state_ff == S_POINT) && !(point_due && out_full);
   assign summary_go = (state_ff == S_SUMMARY) && !out_full;
   assign take = item_valid
      && ((state_ff == S_IDLE) || (point_go && !last_ff) || summary_go);
   assign item_pop = take;

   assign interval = (cfg.points_interval == '0) ? 16'd1 : cfg.points_interval;
   assign phase_next = 17'(phase_ff) + 17'd1;

   always_comb begin
      if (cfg.detector_mode == DETECT_PEAK) begin
         det_value = mag_ff[MAG_BITS-1] ? '1 : mag_ff[ENV_BITS-1:0];
      end else begin
         det_value = (|prod_ff[PROD_BITS-1:2*ENV_BITS]) ? '1
            : prod_ff[2*ENV_BITS-1:ENV_BITS];
      end
      coef_rest = UNITY - (ENV_BITS + 1)'(coef_ff);
      rel_prod = (2 * ENV_BITS + 1)'(coef_rest) * (2 * ENV_BITS + 1)'(det_ff);
      smooth_sum = (2 * ENV_BITS + 1)'(acc_ff) + rel_prod;
      sum_add = (SUM_BITS + 1)'(sum_ff) + (SUM_BITS + 1)'(env_ff);
   end

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      last_in = last_ff;
      prod_in = prod_ff;
      det_in = det_ff;
      coef_in = coef_ff;
      acc_in = acc_ff;
      env_in = env_ff;
      frame_in = frame_ff;
      phase_in = phase_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      out_push = 1'b0;
      out_data.result_kind = KIND_POINT;
      out_data.envelope = env_ff;
      out_data.frame_index = INDEX_BITS'(frame_ff);
      out_data.amplitude_sum = '0;
      out_data.point_count = '0;
      out_data.last = !last_ff;

      unique case (state_ff)
         S_IDLE: begin
         end
         S_DETECT: begin
            prod_in = PROD_BITS'(mag_ff) * PROD_BITS'(mag_ff);
            state_in = S_SMOOTH1;
         end
         S_SMOOTH1: begin
            det_in = det_value;
            coef_in = (det_value > env_ff) ? cfg.attack_coefficient : cfg.release_coefficient;
            acc_in = (2 * ENV_BITS)'(coef_in) * (2 * ENV_BITS)'(env_ff);
            state_in = S_SMOOTH2;
         end
         S_SMOOTH2: begin
            env_in = smooth_sum[2*ENV_BITS-1:ENV_BITS];
            state_in = S_POINT;
         end
         S_POINT: begin
            if (point_go) begin
               if (point_due) begin
                  out_push = 1'b1;
                  sum_in = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
                  if (cnt_ff != COUNT_MAX) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               if (last_ff) begin
                  state_in = S_SUMMARY;
               end else begin
                  frame_in = frame_ff + 1'b1;
                  phase_in = (phase_next >= 17'(interval)) ? '0 : phase_next[15:0];
                  state_in = S_IDLE;
               end
            end
         end
         S_SUMMARY: begin
            out_data.result_kind = KIND_SUMMARY;
            out_data.amplitude_sum = sum_ff;
            out_data.point_count = 32'(cnt_ff);
            out_data.last = 1'b1;
            if (summary_go) begin
               out_push = 1'b1;
               frame_in = '0;
               phase_in = '0;
               sum_in = '0;
               cnt_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (take) begin
         mag_in = item.magnitude;
         last_in = item.last_frame;
         state_in = S_DETECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         env_ff <= '0;
         frame_ff <= '0;
         phase_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         env_ff <= env_in;
         frame_ff <= frame_in;
         phase_ff <= phase_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      last_ff <= last_in;
      prod_ff <= prod_in;
      det_ff <= det_in;
      coef_ff <= coef_in;
      acc_ff <= acc_in;
   end

   a_summary_needs_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUMMARY) |-> last_ff)
      else $error("summary state entered for a frame not marked last");

   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.result_kind == KIND_SUMMARY)
      |=> (sum_ff == '0 && cnt_ff == '0 && frame_ff == '0))
      else $error("run counters not cleared after summary");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_envelope_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SMOOTH2) |=> $stable(env_ff))
      else $error("envelope changed outside the smoothing step");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import arf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASE_FRAMES = 175;
   localparam longint SUM_MAX = (longint'(1) << 48) - 1;
   localparam longint COUNT_MAX = (longint'(1) << 32) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   req_type req_data = '0;
   logic full;
   logic empty;
   logic pop = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = CSR_ATTACK;
   logic [15:0] csr_data = '0;

   attack_release_envelope_follower dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data(req_data),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the configuration and of the envelope and run state.
   longint attack_coef = 65387;
   longint release_coef = 65521;
   logic peak_mode = DETECT_SQUARE;
   logic [1:0] channels = 2'd1;
   longint interval_reg = 1024;
   longint env_level = 0;
   longint frame_count = 0;
   longint phase_count = 0;
   longint run_sum = 0;
   longint run_points = 0;

   req_type frame_queue[$];
   rsp_type expected_results[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_hold = 0;
   bit took_frame = 1'b0;
   int errors = 0;
   int cycles = 0;

   always #1 clock = ~clock;

   function automatic void predict_frame(input req_type f);
      longint left_v;
      longint x;
      longint mag;
      longint det;
      longint coef;
      longint span;
      rsp_type r;
      left_v = longint'($signed(f.sample_left));
      x = (channels == CHANNELS_STEREO) ? left_v + longint'($signed(f.sample_right))
                                        : 2 * left_v;
      mag = (x < 0) ? -x : x;
      det = (peak_mode == DETECT_PEAK) ? mag : ((mag * mag) >> 16);
      if (det > 65535) begin
         det = 65535;
      end
      coef = (det > env_level) ? attack_coef : release_coef;
      env_level = ((coef * env_level + (65536 - coef) * det) >> 16) & 65535;
      span = (interval_reg == 0) ? 1 : interval_reg;
      if (phase_count == 0) begin
         run_sum = run_sum + env_level;
         if (run_sum > SUM_MAX) begin
            run_sum = SUM_MAX;
         end
         if (run_points < COUNT_MAX) begin
            run_points++;
         end
         r.result_kind = KIND_POINT;
         r.envelope = env_level[15:0];
         r.frame_index = frame_count[31:0];
         r.amplitude_sum = '0;
         r.point_count = '0;
         r.last = !f.last_frame;
         expected_results.push_back(r);
      end
      if (f.last_frame) begin
         r.result_kind = KIND_SUMMARY;
         r.envelope = env_level[15:0];
         r.frame_index = frame_count[31:0];
         r.amplitude_sum = run_sum[47:0];
         r.point_count = run_points[31:0];
         r.last = 1'b1;
         expected_results.push_back(r);
         frame_count = 0;
         phase_count = 0;
         run_sum = 0;
         run_points = 0;
      end else begin
         frame_count = (frame_count + 1) & COUNT_MAX;
         phase_count = (phase_count + 1 >= span) ? 0 : phase_count + 1;
      end
   endfunction

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      took_frame = !reset && push && !full;
      if (took_frame) begin
         predict_frame(req_data);
      end
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            $error("result_kind: expected none, actual %0d", rsp_data.result_kind);
            errors++;
         end else begin
            want = expected_results.pop_front();
            compare_field("result_kind", longint'(want.result_kind),
                          longint'(rsp_data.result_kind));
            compare_field("envelope", longint'(want.envelope), longint'(rsp_data.envelope));
            compare_field("frame_index", longint'(want.frame_index),
                          longint'(rsp_data.frame_index));
            compare_field("amplitude_sum", longint'(want.amplitude_sum),
                          longint'(rsp_data.amplitude_sum));
            compare_field("point_count", longint'(want.point_count),
                          longint'(rsp_data.point_count));
            compare_field("last", longint'(want.last), longint'(rsp_data.last));
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!push || took_frame) begin
         if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= frame_queue.pop_front();
            push <= 1'b1;
         end else begin
            push <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold = recv_hold - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      case (index)
         CSR_ATTACK: attack_coef = longint'(value);
         CSR_RELEASE: release_coef = longint'(value);
         CSR_MODE: peak_mode = value[0];
         CSR_CHANNELS: channels = value[1:0];
         CSR_INTERVAL: interval_reg = longint'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] attack, input logic [15:0] release_value,
                            input logic [15:0] mode, input logic [15:0] chans,
                            input logic [15:0] interval);
      write_reg(CSR_ATTACK, attack);
      write_reg(CSR_RELEASE, release_value);
      write_reg(CSR_MODE, mode);
      write_reg(CSR_CHANNELS, chans);
      write_reg(CSR_INTERVAL, interval);
   endtask

   // Waits until every frame is taken and every result has come, then lets the block settle.
   task automatic drain();
      while (frame_queue.size() != 0 || push || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_frame(input logic [15:0] left, input logic [15:0] right,
                              input bit last_flag);
      req_type f;
      f.sample_left = left;
      f.sample_right = right;
      f.last_frame = last_flag;
      frame_queue.push_back(f);
   endtask

   function automatic logic [15:0] random_sample();
      logic [15:0] v;
      case ($urandom_range(0, 3))
         0: v = 16'($urandom_range(0, 511) - 256);
         1: begin
            case ($urandom_range(0, 3))
               0: v = 16'h8000;
               1: v = 16'h7fff;
               2: v = 16'h0000;
               default: v = 16'hffff;
            endcase
         end
         default: v = 16'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   function automatic logic [15:0] random_coef();
      logic [15:0] v;
      case ($urandom_range(0, 3))
         0: v = 16'd0;
         1: v = 16'hffff;
         2: v = 16'($urandom_range(60000, 65535));
         default: v = 16'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   initial begin : stimulus
      int phase;
      int n;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings; the first frame gives a point, the last frame only a summary.
      queue_frame(16'h7fff, 16'h0000, 1'b0);
      queue_frame(16'h8000, 16'h0000, 1'b0);
      queue_frame(16'h0000, 16'h0000, 1'b1);
      drain();

      // Stereo peak detection with a zero interval, so every frame gives a point.
      configure(16'd0, 16'hffff, 16'(DETECT_PEAK), 16'(CHANNELS_STEREO), 16'd0);
      queue_frame(16'h8000, 16'h8000, 1'b0);
      queue_frame(16'h7fff, 16'h7fff, 1'b0);
      queue_frame(16'h8000, 16'h7fff, 1'b0);
      queue_frame(16'h7fff, 16'h8000, 1'b1);
      queue_frame(16'h0000, 16'h0000, 1'b0);
      drain();

      // A channel count of three means mono; the interval is then lowered below the phase.
      configure(16'hffff, 16'd0, 16'(DETECT_SQUARE), 16'd3, 16'd8);
      queue_frame(16'h8000, 16'd12345, 1'b0);
      queue_frame(16'h4000, 16'hffff, 1'b0);
      queue_frame(16'hffff, 16'hffff, 1'b0);
      queue_frame(16'h0001, 16'h0001, 1'b0);
      queue_frame(16'h00c8, 16'hff38, 1'b0);
      drain();
      write_reg(CSR_INTERVAL, 16'd2);
      write_reg(CSR_CHANNELS, 16'd0);
      queue_frame(16'h8000, 16'h8000, 1'b0);
      queue_frame(16'h7fff, 16'h7fff, 1'b0);
      queue_frame(16'h012c, 16'h0000, 1'b1);
      drain();

      configure(16'hffff, 16'hffff, 16'(DETECT_PEAK), 16'd1, 16'd1);
      queue_frame(16'h8000, 16'h0000, 1'b0);
      queue_frame(16'h7fff, 16'h0005, 1'b0);
      queue_frame(16'hffff, 16'h0000, 1'b1);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         if (phase == 0) begin
            configure(16'd0, 16'd0, 16'(DETECT_SQUARE), 16'd1, 16'd1);
         end else if (phase == 1) begin
            configure(16'hffff, 16'hffff, 16'(DETECT_PEAK), 16'(CHANNELS_STEREO), 16'hffff);
         end else begin
            configure(random_coef(), random_coef(), 16'($urandom_range(0, 1)),
                      16'($urandom_range(0, 3)),
                      (phase == 6) ? 16'd1
                      : ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(0, 6)));
         end
         send_idle_pct = (phase < 3) ? 19 : (phase < 6) ? 79 : 0;
         recv_idle_pct = (phase < 3) ? 79 : (phase < 6) ? 19 : 0;
         if (phase == 6) begin
            recv_hold = 400;
         end
         for (n = 0; n < PHASE_FRAMES; n++) begin
            queue_frame(random_sample(), random_sample(), $urandom_range(0, 39) == 0);
         end
         drain();
      end

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== attack_release_envelope_follower.f =====
sv/arf_pkg.sv
sv/arf_fifo.sv
sv/arf_front.sv
sv/arf_back.sv
sv/attack_release_envelope_follower.sv
verif/tb.sv
